>>> design/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants and the arctangent table for the quaternion to Euler block.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int QUAT_FRAC_BITS_DEF = 30;
    localparam int CORDIC_STAGES_DEF  = 16;
    localparam int ATAN_TABLE_LEN     = 24;
    localparam int ANGLE_FRAC         = 30;
    localparam int ANGLE_W            = 34;   // radians, 30 fraction bits, +/- 8 rad

    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // atan(2^-i) * 2^30, truncated
    function automatic logic signed [ANGLE_W-1:0] atan_entry(input int idx);
        logic signed [ANGLE_W-1:0] v;
        unique case (idx)
            0:  v = 34'sd843314856;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043836;
            3:  v = 34'sd133525158;
            4:  v = 34'sd67021686;
            5:  v = 34'sd33543515;
            6:  v = 34'sd16775850;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194282;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048575;
            11: v = 34'sd524287;
            12: v = 34'sd262143;
            13: v = 34'sd131071;
            14: v = 34'sd65535;
            15: v = 34'sd32767;
            16: v = 34'sd16383;
            17: v = 34'sd8191;
            18: v = 34'sd4095;
            19: v = 34'sd2047;
            20: v = 34'sd1023;
            21: v = 34'sd511;
            22: v = 34'sd255;
            23: v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> design/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ----------------------------------------------------------------------------
module qte_isqrt
    import qte_pkg::*;
#(
    parameter int ROOT_W = QUAT_FRAC_BITS_DEF + 1
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [2*ROOT_W-1:0]   rad,
    output logic [ROOT_W-1:0]     root
);

    localparam int REM_W = ROOT_W + 2;

    logic [2*ROOT_W-1:0] v_reg    [0:ROOT_W];
    logic [REM_W-1:0]    rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]   root_reg [0:ROOT_W];

    always_comb begin
        v_reg[0]    = rad;
        rem_reg[0]  = '0;
        root_reg[0] = '0;
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb begin
            rem_sh = {rem_reg[k][REM_W-3:0], v_reg[k][2*(ROOT_W-1-k) +: 2]};
            trial  = {root_reg[k], 2'b01};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[k][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[k][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[k+1]    <= v_reg[k];
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
            end
        end
    end

    assign root = root_reg[ROOT_W];

endmodule

>>> design/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC atan2: quarter-turn pre-rotation, then one
// micro-rotation per stage. Zero vector gives angle 0.
// ----------------------------------------------------------------------------
module qte_cordic
    import qte_pkg::*;
#(
    parameter int IN_W   = QUAT_FRAC_BITS_DEF + 2,
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [IN_W-1:0]    y_in,
    input  logic signed [IN_W-1:0]    x_in,
    output logic signed [ANGLE_W-1:0] z_out
);

    localparam int XW = IN_W + 3;

    logic signed [XW-1:0]      x_reg [0:STAGES];
    logic signed [XW-1:0]      y_reg [0:STAGES];
    logic signed [ANGLE_W-1:0] z_reg [0:STAGES];
    logic                      zero_reg [0:STAGES];

    logic signed [XW-1:0]      xe, ye;
    logic signed [XW-1:0]      x0_next, y0_next;
    logic signed [ANGLE_W-1:0] z0_next;

    // quarter turn for the left half-plane
    always_comb begin
        xe = XW'(x_in);
        ye = XW'(y_in);
        if (xe < 0) begin
            if (ye >= 0) begin
                x0_next = ye;
                y0_next = -xe;
                z0_next = HALF_PI_Q30;
            end else begin
                x0_next = -ye;
                y0_next = xe;
                z0_next = -HALF_PI_Q30;
            end
        end else begin
            x0_next = xe;
            y0_next = ye;
            z0_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        logic signed [XW-1:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
            end
        end
    end

    assign z_out = zero_reg[STAGES] ? '0 : z_reg[STAGES];

endmodule

>>> design/quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Unit quaternion (Q2.F) in, pitch / roll / yaw in hundredths of a degree out.
// ----------------------------------------------------------------------------
// Pipeline: products, operands, s^2, 1 - s^2, the bit-per-stage square root,
//   the CORDIC pre-rotation and micro-rotation stages, scale, output register.
// Throughput: one request per cycle; the whole pipe advances whenever the
//   output register is empty or being taken, and holds together on a stall.
// Reset: aresetn (synchronous, active low) clears the valid bits only.
// Requests with s_quat_present low are taken but give no result.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top
    import qte_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_quat_present,
    input  logic signed [31:0] s_quat_w,
    input  logic signed [31:0] s_quat_x,
    input  logic signed [31:0] s_quat_y,
    input  logic signed [31:0] s_quat_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [14:0] m_pitch_angle,
    output logic signed [15:0] m_roll_angle,
    output logic signed [15:0] m_yaw_angle
);

    // widths
    localparam int QF    = QUAT_FRAC_BITS;
    localparam int PW    = 64 - QF;          // product after >>> QF
    localparam int SW    = PW + 3;           // operand sums
    localparam int OW    = QF + 2;           // saturated Q2.F operand
    localparam int NR    = QF + 1;           // square root width
    localparam int RW    = 2 * NR;           // radicand width
    localparam int DLY   = NR + 2;           // operand delay across s^2 / sqrt
    localparam int VL    = NR + CORDIC_STAGES + 6;  // internal valid stages
    localparam int SPW   = ANGLE_W + 14;     // scaled angle product
    localparam int RDW   = SPW - ANGLE_FRAC; // rounded hundredths

    localparam logic signed [SW-1:0]  ONE_S   = SW'(1) <<< QF;
    localparam logic signed [SW-1:0]  LIM_S   = SW'(2) <<< QF;
    localparam logic signed [OW-1:0]  ONE_O   = OW'(1) <<< QF;
    localparam logic        [RW-1:0]  ONE_SQ  = RW'(1) << (2 * QF);
    localparam logic signed [13:0]    DEG     = 14'sd5730;
    localparam logic signed [SPW-1:0] HALF_LSB = SPW'(1) <<< (ANGLE_FRAC - 1);
    localparam logic signed [RDW-1:0] PITCH_LIM = RDW'(9010);
    localparam logic signed [RDW-1:0] RY_LIM    = RDW'(18010);

    // saturate a sum to Q2.F
    function automatic logic signed [OW-1:0] sat_q(input logic signed [SW-1:0] v);
        logic signed [OW-1:0] r;
        if (v < -LIM_S)         r = OW'(-LIM_S);
        else if (v > LIM_S - 1) r = OW'(LIM_S - 1);
        else                    r = v[OW-1:0];
        return r;
    endfunction

    function automatic logic signed [RDW-1:0] clamp_r(input logic signed [RDW-1:0] v,
                                                      input logic signed [RDW-1:0] lim);
        logic signed [RDW-1:0] r;
        if (v < -lim)     r = -lim;
        else if (v > lim) r = lim;
        else              r = v;
        return r;
    endfunction

    logic [VL-1:0] vld_reg;
    logic          m_valid_reg;

    // pipe advances when the output slot is free or being drained
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[VL-2:0], s_valid && s_quat_present};
            m_valid_reg <= vld_reg[VL-1];
        end
    end

    // stage 1: the ten component products, each one multiplier
    logic signed [63:0] m_wy, m_xz, m_yz, m_wx, m_xx, m_yy, m_xy, m_wz, m_ww, m_zz;
    assign m_wy = s_quat_w * s_quat_y;
    assign m_xz = s_quat_x * s_quat_z;
    assign m_yz = s_quat_y * s_quat_z;
    assign m_wx = s_quat_w * s_quat_x;
    assign m_xx = s_quat_x * s_quat_x;
    assign m_yy = s_quat_y * s_quat_y;
    assign m_xy = s_quat_x * s_quat_y;
    assign m_wz = s_quat_w * s_quat_z;
    assign m_ww = s_quat_w * s_quat_w;
    assign m_zz = s_quat_z * s_quat_z;

    logic signed [PW-1:0] p_wy_reg, p_xz_reg, p_yz_reg, p_wx_reg, p_xx_reg;
    logic signed [PW-1:0] p_yy_reg, p_xy_reg, p_wz_reg, p_ww_reg, p_zz_reg;

    // keeping the top bits is the floor shift by QF
    always_ff @(posedge aclk) begin
        if (en) begin
            p_wy_reg <= m_wy[63:QF];
            p_xz_reg <= m_xz[63:QF];
            p_yz_reg <= m_yz[63:QF];
            p_wx_reg <= m_wx[63:QF];
            p_xx_reg <= m_xx[63:QF];
            p_yy_reg <= m_yy[63:QF];
            p_xy_reg <= m_xy[63:QF];
            p_wz_reg <= m_wz[63:QF];
            p_ww_reg <= m_ww[63:QF];
            p_zz_reg <= m_zz[63:QF];
        end
    end

    // stage 2: trig operands, saturation, asin clamp
    logic signed [SW-1:0] s_sum, sr_sum, cr_sum, sy_sum, cy_sum;
    logic signed [OW-1:0] s_sat, s_next;

    always_comb begin
        s_sum  = (SW'(p_wy_reg) - SW'(p_xz_reg)) <<< 1;
        sr_sum = (SW'(p_yz_reg) + SW'(p_wx_reg)) <<< 1;
        cr_sum = ONE_S - (SW'(p_xx_reg) <<< 1) - (SW'(p_yy_reg) <<< 1);
        sy_sum = (SW'(p_xy_reg) + SW'(p_wz_reg)) <<< 1;
        cy_sum = SW'(p_ww_reg) + SW'(p_xx_reg) - SW'(p_yy_reg) - SW'(p_zz_reg);
        s_sat  = sat_q(s_sum);
        if (s_sat > ONE_O)       s_next = ONE_O;
        else if (s_sat < -ONE_O) s_next = -ONE_O;
        else                     s_next = s_sat;
    end

    // operand delay line; entry 0 is the stage 2 register
    logic signed [OW-1:0] s_dly_reg  [0:DLY];
    logic signed [OW-1:0] sr_dly_reg [0:DLY];
    logic signed [OW-1:0] cr_dly_reg [0:DLY];
    logic signed [OW-1:0] sy_dly_reg [0:DLY];
    logic signed [OW-1:0] cy_dly_reg [0:DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            s_dly_reg[0]  <= s_next;
            sr_dly_reg[0] <= sat_q(sr_sum);
            cr_dly_reg[0] <= sat_q(cr_sum);
            sy_dly_reg[0] <= sat_q(sy_sum);
            cy_dly_reg[0] <= sat_q(cy_sum);
            for (int d = 1; d <= DLY; d++) begin
                s_dly_reg[d]  <= s_dly_reg[d-1];
                sr_dly_reg[d] <= sr_dly_reg[d-1];
                cr_dly_reg[d] <= cr_dly_reg[d-1];
                sy_dly_reg[d] <= sy_dly_reg[d-1];
                cy_dly_reg[d] <= cy_dly_reg[d-1];
            end
        end
    end

    // stage 3: s^2; stage 4: 1 - s^2
    logic signed [2*OW-1:0] sq_reg;
    logic        [RW-1:0]   rad_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg  <= s_dly_reg[0] * s_dly_reg[0];
            rad_reg <= ONE_SQ - sq_reg[RW-1:0];
        end
    end

    // cos(pitch) = floor(sqrt(1 - s^2))
    logic [NR-1:0] c_root;

    qte_isqrt #(
        .ROOT_W (NR)
    ) u_isqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (rad_reg),
        .root (c_root)
    );

    // three atan2 pipes in lock step
    logic signed [ANGLE_W-1:0] z_pitch, z_roll, z_yaw;

    qte_cordic #(
        .IN_W   (OW),
        .STAGES (CORDIC_STAGES)
    ) u_cordic_pitch (
        .aclk  (aclk),
        .en    (en),
        .y_in  (s_dly_reg[DLY]),
        .x_in  ({1'b0, c_root}),
        .z_out (z_pitch)
    );

    qte_cordic #(
        .IN_W   (OW),
        .STAGES (CORDIC_STAGES)
    ) u_cordic_roll (
        .aclk  (aclk),
        .en    (en),
        .y_in  (sr_dly_reg[DLY]),
        .x_in  (cr_dly_reg[DLY]),
        .z_out (z_roll)
    );

    qte_cordic #(
        .IN_W   (OW),
        .STAGES (CORDIC_STAGES)
    ) u_cordic_yaw (
        .aclk  (aclk),
        .en    (en),
        .y_in  (sy_dly_reg[DLY]),
        .x_in  (cy_dly_reg[DLY]),
        .z_out (z_yaw)
    );

    // scale: radians * 5730, then round half up and clamp
    logic signed [SPW-1:0] sc_pitch_reg, sc_roll_reg, sc_yaw_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_pitch_reg <= SPW'(z_pitch) * SPW'(DEG);
            sc_roll_reg  <= SPW'(z_roll)  * SPW'(DEG);
            sc_yaw_reg   <= SPW'(z_yaw)   * SPW'(DEG);
        end
    end

    logic signed [SPW-1:0] rp_sum, rr_sum, ry_sum;
    logic signed [RDW-1:0] pitch_next, roll_next, yaw_next;

    always_comb begin
        rp_sum     = sc_pitch_reg + HALF_LSB;
        rr_sum     = sc_roll_reg  + HALF_LSB;
        ry_sum     = sc_yaw_reg   + HALF_LSB;
        pitch_next = clamp_r(rp_sum[SPW-1:ANGLE_FRAC], PITCH_LIM);
        roll_next  = clamp_r(rr_sum[SPW-1:ANGLE_FRAC], RY_LIM);
        yaw_next   = clamp_r(ry_sum[SPW-1:ANGLE_FRAC], RY_LIM);
    end

    logic signed [14:0] pitch_reg;
    logic signed [15:0] roll_reg, yaw_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pitch_reg <= pitch_next[14:0];
            roll_reg  <= roll_next[15:0];
            yaw_reg   <= yaw_next[15:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pitch_angle = pitch_reg;
    assign m_roll_angle  = roll_reg;
    assign m_yaw_angle   = yaw_reg;

    // a stalled pipe must keep every in-flight request
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pitch_angle >= -15'sd9010) && (m_pitch_angle <= 15'sd9010))
        else $error("pitch out of range");

    a_roll_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_roll_angle >= -16'sd18010) && (m_roll_angle <= 16'sd18010)
                 && (m_yaw_angle >= -16'sd18010) && (m_yaw_angle <= 16'sd18010))
        else $error("roll or yaw out of range");

endmodule
